@@ sv/mwms_pkg.sv @@
package mwms_pkg;

  // input beat layout, lowest bit first
  localparam int CMD_W  = 3;
  localparam int COORD_W = 4;
  localparam int DIR_W  = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;
  localparam int CELL_W = 6;

  typedef logic [CELL_W-1:0] cell_t;

  localparam logic REG_MAZE_WIDTH  = 1'b0;
  localparam logic REG_MAZE_HEIGHT = 1'b1;

  localparam logic [CMD_W-1:0] CMD_WALL  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FLAG  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BOX   = 3'd4;

  localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd1;
  localparam logic [DIR_W-1:0] DIR_EAST  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

  localparam logic FLAG_VISITED   = 1'b0;
  localparam logic FLAG_UNCERTAIN = 1'b1;

  localparam cell_t BIT_N   = 6'h01;
  localparam cell_t BIT_S   = 6'h02;
  localparam cell_t BIT_E   = 6'h04;
  localparam cell_t BIT_W   = 6'h08;
  localparam cell_t BIT_VIS = 6'h10;
  localparam cell_t BIT_UNC = 6'h20;

  localparam cell_t CELL_ZERO = 6'h00;

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_MOD    = 8'b0000_0100,
    S_NB     = 8'b0000_1000,
    S_CLR    = 8'b0001_0000,
    S_BOX    = 8'b0010_0000,
    S_BOXEND = 8'b0100_0000,
    S_OWN    = 8'b1000_0000
  } state_t;

endpackage

@@ sv/mwms_ram.sv @@
module mwms_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/maze_wall_map_store.sv @@
// Wall map of a grid maze, one 6-bit cell per grid square (walls N/S/E/W, visited,
// uncertain) held in a single memory with one write and one registered read port.
// Every command beat returns one result beat: the addressed cell after the command.
// Read, flag write and a wall write whose neighbour lies off the grid read the cell,
// then modify and write it back; a wall write that also touches the neighbour
// then reads, modifies and writes back the neighbour too. Clear-all sweeps every
// entry. Drawing the box walks the configured width*height cells with a pipelined
// read-modify-write. After reset a clearing pass over every entry runs before the
// first command is taken; size registers may be written meanwhile.
// A finished result waits in a two-deep output buffer, so a stalled output does not
// hold up the next command until both places are full.
module maze_wall_map_store #(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wen,
  input  logic                                cfg_addr,
  input  logic [4:0]                          cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cmd[2:0], col[6:3], row[10:7], direction[12:11], flag_select[13], set_value[14]
  input  logic [mwms_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // north_present[0], south_present[1], east_present[2], west_present[3],
  // visited_mark[4], uncertain_mark[5]
  output logic [mwms_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  import mwms_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = ($clog2(MAX_COLUMNS + 1) > 5) ? $clog2(MAX_COLUMNS + 1) : 5;
  localparam int YW    = ($clog2(MAX_ROWS + 1) > 5) ? $clog2(MAX_ROWS + 1) : 5;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y);
    cell_addr = AW'(AW'(y) * AW'(MAX_COLUMNS) + AW'(x));
  endfunction

  // configuration
  logic [4:0] maze_width_r, maze_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maze_width_r  <= 5'd16;
      maze_height_r <= 5'd16;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_MAZE_WIDTH:  maze_width_r  <= cfg_wdata;
        REG_MAZE_HEIGHT: maze_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sizes clamped into 1..MAX
  logic [XW-1:0] eff_w;
  logic [YW-1:0] eff_h;

  always_comb begin
    eff_w = XW'(maze_width_r);
    if (maze_width_r == 5'd0) eff_w = XW'(1);
    else if (XW'(maze_width_r) > XW'(MAX_COLUMNS)) eff_w = XW'(MAX_COLUMNS);
    eff_h = YW'(maze_height_r);
    if (maze_height_r == 5'd0) eff_h = YW'(1);
    else if (YW'(maze_height_r) > YW'(MAX_ROWS)) eff_h = YW'(MAX_ROWS);
  end

  // input beat fields
  logic [CMD_W-1:0]   in_cmd;
  logic [COORD_W-1:0] in_col, in_row;

  assign in_cmd = in_tdata[2:0];
  assign in_col = in_tdata[6:3];
  assign in_row = in_tdata[10:7];

  // state
  state_t             state_r, state_nxt;
  logic [CMD_W-1:0]   cmd_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic [DIR_W-1:0]   dir_r;
  logic               fsel_r, set_r;
  logic [XW-1:0]      wx_r, wx_nxt, bx_r;
  logic [YW-1:0]      wy_r, wy_nxt, by_r;
  logic               bv_r, bv_nxt;
  logic               out_valid_r, pend_v_r;
  cell_t              out_r, pend_r;

  // memory ports
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  cell_t         wr_data, rd_data;

  mwms_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic in_acc;
  assign in_tready = (state_r == S_IDLE) && !pend_v_r;
  assign in_acc    = in_tvalid && in_tready;

  // addressed cell of the held command
  logic [XW-1:0] own_x;
  logic [YW-1:0] own_y;
  logic          own_in;

  assign own_x  = XW'(col_r);
  assign own_y  = YW'(row_r);
  assign own_in = (own_x < XW'(MAX_COLUMNS)) && (own_y < YW'(MAX_ROWS));

  // neighbour of a wall write
  logic [XW-1:0] nb_x;
  logic [YW-1:0] nb_y;
  logic          nb_cond, nb_ok;
  cell_t         nb_bit, own_bit, own_new;

  always_comb begin
    nb_x    = own_x;
    nb_y    = own_y;
    nb_cond = 1'b0;
    nb_bit  = BIT_S;
    own_bit = BIT_N;
    case (dir_r)
      DIR_NORTH: begin
        own_bit = BIT_N;
        nb_y    = own_y + YW'(1);
        nb_cond = nb_y < eff_h;
        nb_bit  = BIT_S;
      end
      DIR_SOUTH: begin
        own_bit = BIT_S;
        nb_y    = own_y - YW'(1);
        nb_cond = own_y != '0;
        nb_bit  = BIT_N;
      end
      DIR_EAST: begin
        own_bit = BIT_E;
        nb_x    = own_x + XW'(1);
        nb_cond = nb_x < eff_w;
        nb_bit  = BIT_W;
      end
      DIR_WEST: begin
        own_bit = BIT_W;
        nb_x    = own_x - XW'(1);
        nb_cond = own_x != '0;
        nb_bit  = BIT_E;
      end
      default: ;
    endcase
    nb_ok = nb_cond && (nb_x < XW'(MAX_COLUMNS)) && (nb_y < YW'(MAX_ROWS));
    if (cmd_r == CMD_FLAG) begin
      own_bit = (fsel_r == FLAG_UNCERTAIN) ? BIT_UNC : BIT_VIS;
    end
    own_new = set_r ? (rd_data | own_bit) : (rd_data & ~own_bit);
  end

  logic own_write;
  assign own_write = own_in && (cmd_r inside {CMD_WALL, CMD_FLAG});

  // grid walker for the reset clear, clear and box
  logic [XW-1:0] lim_x;
  logic [YW-1:0] lim_y;
  logic          walk_last;
  cell_t         box_mask;

  always_comb begin
    lim_x = XW'(MAX_COLUMNS);
    lim_y = YW'(MAX_ROWS);
    if (state_r == S_BOX) begin
      lim_x = eff_w;
      lim_y = eff_h;
    end
    walk_last = (wx_r == lim_x - XW'(1)) && (wy_r == lim_y - YW'(1));
    box_mask = CELL_ZERO;
    if (by_r == '0)                box_mask = box_mask | BIT_S;
    if (by_r == eff_h - YW'(1))    box_mask = box_mask | BIT_N;
    if (bx_r == '0)                box_mask = box_mask | BIT_W;
    if (bx_r == eff_w - XW'(1))    box_mask = box_mask | BIT_E;
  end

  always_comb begin
    state_nxt = state_r;
    wx_nxt    = wx_r;
    wy_nxt    = wy_r;
    bv_nxt    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cell_addr(own_x, own_y);
    wr_data   = own_new;
    rd_en     = 1'b0;
    rd_addr   = cell_addr(own_x, own_y);
    if (state_r inside {S_INIT, S_CLR, S_BOX}) begin
      if (walk_last) begin
        wx_nxt = '0;
        wy_nxt = '0;
      end else if (wx_r == lim_x - XW'(1)) begin
        wx_nxt = '0;
        wy_nxt = wy_r + YW'(1);
      end else begin
        wx_nxt = wx_r + XW'(1);
      end
    end
    case (state_r)
      S_INIT, S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = cell_addr(wx_r, wy_r);
        wr_data = CELL_ZERO;
        if (walk_last) state_nxt = (state_r == S_INIT) ? S_IDLE : S_OWN;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_CLEAR: state_nxt = S_CLR;
            CMD_BOX:   state_nxt = S_BOX;
            default: begin
              rd_en     = 1'b1;
              rd_addr   = cell_addr(XW'(in_col), YW'(in_row));
              state_nxt = S_MOD;
            end
          endcase
        end
      end
      S_BOX: begin
        // read this cell, write back the one read last cycle
        rd_en   = 1'b1;
        rd_addr = cell_addr(wx_r, wy_r);
        bv_nxt  = 1'b1;
        wr_en   = bv_r;
        wr_addr = cell_addr(bx_r, by_r);
        wr_data = rd_data | box_mask;
        if (walk_last) state_nxt = S_BOXEND;
      end
      S_BOXEND: begin
        wr_en     = bv_r;
        wr_addr   = cell_addr(bx_r, by_r);
        wr_data   = rd_data | box_mask;
        state_nxt = S_OWN;
      end
      S_OWN: begin
        rd_en     = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        wr_en     = own_write;
        state_nxt = S_IDLE;
        if (cmd_r == CMD_WALL && nb_ok) begin
          rd_en     = 1'b1;
          rd_addr   = cell_addr(nb_x, nb_y);
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        wr_en     = 1'b1;
        wr_addr   = cell_addr(nb_x, nb_y);
        wr_data   = set_r ? (rd_data | nb_bit) : (rd_data & ~nb_bit);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result of the held command
  cell_t res;
  logic  res_v, out_free;

  always_comb begin
    res = CELL_ZERO;
    if (own_in) res = own_write ? own_new : rd_data;
  end

  assign res_v    = state_r == S_MOD;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      wx_r        <= '0;
      wy_r        <= '0;
      bv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wx_r    <= wx_nxt;
      wy_r    <= wy_nxt;
      bv_r    <= bv_nxt;
      if (res_v) begin
        if (out_free) out_valid_r <= 1'b1;
        else          pend_v_r    <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= pend_v_r;
        pend_v_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_cmd;
      col_r  <= in_col;
      row_r  <= in_row;
      dir_r  <= in_tdata[12:11];
      fsel_r <= in_tdata[13];
      set_r  <= in_tdata[14];
    end
    if (state_r == S_BOX) begin
      bx_r <= wx_r;
      by_r <= wy_r;
    end
    if (res_v) begin
      if (out_free) out_r  <= res;
      else          pend_r <= res;
    end else if (out_free && pend_v_r) begin
      out_r <= pend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_r);

`ifndef NO_ASSERTIONS
  // the spare result place fills only behind a waiting beat
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> out_valid_r)
    else $error("pending result without a held output beat");

  // a single-cell command goes straight to the modify step
  a_plain_to_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd != CMD_CLEAR && in_cmd != CMD_BOX) |=> state_r == S_MOD)
    else $error("single-cell command did not reach modify step");

  // never read an entry in the cycle it is written
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en && wr_addr == rd_addr))
    else $error("read and write of the same entry in one cycle");

  // every accepted command produces a result beat before the next is taken
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |=> (out_valid_r || pend_v_r))
    else $error("modify step produced no result");
`endif

endmodule
